// ===== rtl/core/tcsa_pkg.sv =====
package tcsa_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TICK_W     = 16;

	localparam logic [TICK_W-1:0] TICK_MAX             = '1;
	localparam logic [TICK_W-1:0] VBUS_DEBOUNCE_RESET  = 16'd150;
	localparam logic [TICK_W-1:0] CC_POLL_RESET        = 16'd20;

	// register index, taken from paddr[2]
	localparam logic REG_VBUS_DEBOUNCE = 1'b0;
	localparam logic REG_CC_POLL       = 1'b1;

	typedef enum logic [1:0] {
		ST_DETACHED  = 2'd0,
		ST_DETECTING = 2'd1,
		ST_ATTACHED  = 2'd2
	} conn_state_t;

	typedef enum logic [1:0] {
		POL_NONE = 2'd0,
		POL_CC1  = 2'd1,
		POL_CC2  = 2'd2
	} polarity_t;

	typedef enum logic [1:0] {
		EVT_NONE     = 2'd0,
		EVT_ATTACHED = 2'd1,
		EVT_DETACHED = 2'd2
	} dpm_event_t;

	typedef struct packed {
		logic [TICK_W-1:0] vbus_debounce_ticks;
		logic [TICK_W-1:0] cc_poll_ticks;
	} cfg_t;

	typedef struct packed {
		logic       tick;
		logic       vbus_present;
		logic       polarity_done;
		logic       scan_ready;
		logic [1:0] cc1_level;
		logic [1:0] cc2_level;
	} item_t;

	typedef struct packed {
		conn_state_t        fsm_state;
		logic [TICK_W-1:0]  debounce_count;
		logic               debounce_running;
		logic [TICK_W-1:0]  poll_count;
		logic               poll_running;
		logic [1:0]         last_cc1;
		logic [1:0]         last_cc2;
		logic               port_attached;
	} ctx_t;

	typedef struct packed {
		conn_state_t conn_state;
		logic        attached_flag;
		logic        scan_request;
		logic        polarity_request;
		polarity_t   polarity_choice;
		dpm_event_t  dpm_event;
	} result_t;

endpackage

// ===== rtl/core/tcsa_if.sv =====
interface tcsa_item_if;
	logic       valid;
	logic       ready;
	logic       tick;
	logic       vbus_present;
	logic       polarity_done;
	logic       scan_ready;
	logic [1:0] cc1_level;
	logic [1:0] cc2_level;

	modport source (output valid, tick, vbus_present, polarity_done, scan_ready,
		cc1_level, cc2_level, input ready);
	modport sink (input valid, tick, vbus_present, polarity_done, scan_ready,
		cc1_level, cc2_level, output ready);
endinterface

interface tcsa_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] conn_state;
	logic       attached_flag;
	logic       scan_request;
	logic       polarity_request;
	logic [1:0] polarity_choice;
	logic [1:0] dpm_event;

	modport source (output valid, conn_state, attached_flag, scan_request,
		polarity_request, polarity_choice, dpm_event, input ready);
	modport sink (input valid, conn_state, attached_flag, scan_request,
		polarity_request, polarity_choice, dpm_event, output ready);
endinterface

// ===== rtl/core/tcsa_cfg_regs.sv =====
module tcsa_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcsa_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [tcsa_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [tcsa_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output tcsa_pkg::cfg_t                  cfg
);
	import tcsa_pkg::*;

	logic [TICK_W-1:0] debounce_q;
	logic [TICK_W-1:0] poll_q;
	logic              wr_en;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= VBUS_DEBOUNCE_RESET;
			poll_q     <= CC_POLL_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_VBUS_DEBOUNCE: debounce_q <= pwdata[TICK_W-1:0];
				REG_CC_POLL:       poll_q     <= pwdata[TICK_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_VBUS_DEBOUNCE: prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, debounce_q};
			REG_CC_POLL:       prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, poll_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.vbus_debounce_ticks = debounce_q;
	assign cfg.cc_poll_ticks       = poll_q;

endmodule

// ===== rtl/core/tcsa_step.sv =====
module tcsa_step (
	input  tcsa_pkg::cfg_t    cfg,
	input  tcsa_pkg::ctx_t    ctx,
	input  tcsa_pkg::item_t   item,
	output tcsa_pkg::ctx_t    ctx_nxt,
	output tcsa_pkg::result_t res
);
	import tcsa_pkg::*;

	ctx_t       n;
	logic       scan, preq;
	polarity_t  pchoice;
	dpm_event_t evt;
	logic       go;

	always_comb begin
		n       = ctx;
		scan    = 1'b0;
		preq    = 1'b0;
		pchoice = POL_NONE;
		evt     = EVT_NONE;
		go      = 1'b1;

		// timers advance first, saturating
		if (item.tick) begin
			if (n.debounce_running && n.debounce_count != TICK_MAX)
				n.debounce_count = n.debounce_count + 1'b1;
			if (n.poll_running && n.poll_count != TICK_MAX)
				n.poll_count = n.poll_count + 1'b1;
		end

		case (ctx.fsm_state)
			ST_DETECTING: begin
				if (n.poll_running) begin
					if (n.poll_count < cfg.cc_poll_ticks) begin
						go = 1'b0;
					end else begin
						n.poll_running = 1'b0;
						n.poll_count   = '0;
						scan           = 1'b1;
					end
				end
				if (go && item.scan_ready) begin
					if (!item.vbus_present) begin
						n.poll_running     = 1'b0;
						n.poll_count       = '0;
						n.fsm_state        = ST_DETACHED;
						n.port_attached    = 1'b0;
						n.debounce_running = 1'b0;
						n.debounce_count   = '0;
						evt                = EVT_DETACHED;
						preq               = 1'b1;
						pchoice            = POL_NONE;
					end else if (item.cc1_level != item.cc2_level &&
							item.cc1_level == n.last_cc1 &&
							item.cc2_level == n.last_cc2) begin
						preq           = 1'b1;
						pchoice        = (item.cc1_level > item.cc2_level) ? POL_CC1 : POL_CC2;
						n.poll_running = 1'b0;
						n.poll_count   = '0;
						n.fsm_state    = ST_ATTACHED;
					end else begin
						n.last_cc1     = item.cc1_level;
						n.last_cc2     = item.cc2_level;
						n.poll_running = 1'b1;
						n.poll_count   = '0;
					end
				end
			end
			ST_ATTACHED: begin
				if (!n.port_attached) begin
					if (!item.polarity_done) begin
						go = 1'b0;
					end else begin
						n.port_attached = 1'b1;
						evt             = EVT_ATTACHED;
					end
				end
				// VBUS loss in the attach step: detached event wins
				if (go && !item.vbus_present) begin
					n.fsm_state        = ST_DETACHED;
					n.port_attached    = 1'b0;
					n.debounce_running = 1'b0;
					n.debounce_count   = '0;
					evt                = EVT_DETACHED;
					preq               = 1'b1;
					pchoice            = POL_NONE;
				end
			end
			default: begin
				n.fsm_state = ST_DETACHED;
				if (item.polarity_done) begin
					if (!item.vbus_present) begin
						n.debounce_running = 1'b0;
						n.debounce_count   = '0;
					end else if (!n.debounce_running) begin
						n.debounce_running = 1'b1;
						n.debounce_count   = '0;
					end else if (n.debounce_count >= cfg.vbus_debounce_ticks) begin
						n.debounce_running = 1'b0;
						n.debounce_count   = '0;
						n.fsm_state        = ST_DETECTING;
						n.last_cc1         = '0;
						n.last_cc2         = '0;
						scan               = 1'b1;
						n.poll_running     = 1'b0;
						n.poll_count       = '0;
					end
				end
			end
		endcase

		ctx_nxt              = n;
		res.conn_state       = n.fsm_state;
		res.attached_flag    = n.port_attached;
		res.scan_request     = scan;
		res.polarity_request = preq;
		res.polarity_choice  = pchoice;
		res.dpm_event        = evt;
	end

endmodule

// ===== rtl/core/type_c_sink_attach_fsm.sv =====
// USB Type-C sink attach/detach controller. Each transfer on item is one
// system update (timer tick flag, VBUS level, polarity-done, CC scan result)
// and produces exactly one transfer on result with the connection state and
// the pulses for that update (scan request, polarity request and choice, DPM
// attach/detach event). Throughput is one transfer per cycle while result is
// not back-pressured. The item lands in the input register at its acceptance
// edge; the state update is committed and the result register loaded when
// the item advances out of the input register, after which result is valid.
// Back pressure on result stalls the input register, which in turn drops
// item.ready. Timing
// registers live on the APB port: offset 0x0 VBUS debounce ticks (reset 150),
// offset 0x4 CC poll interval ticks (reset 20), 16 bits each, read back
// zero-extended. Write them only while no update is in flight. After reset
// the controller sits in DETACHED with no event pending.
module type_c_sink_attach_fsm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tcsa_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [tcsa_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [tcsa_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	tcsa_item_if.sink                       item,
	tcsa_result_if.source                   result
);
	import tcsa_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	ctx_t    ctx_q;
	ctx_t    ctx_nxt;
	result_t res_nxt;
	result_t result_q;
	logic    result_valid_q;
	logic    advance;   // stage 1 item moves into the result register

	tcsa_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcsa_step u_step (
		.cfg     (cfg),
		.ctx     (ctx_q),
		.item    (item_s1),
		.ctx_nxt (ctx_nxt),
		.res     (res_nxt)
	);

	// result slot frees when empty or being taken this cycle
	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.tick          <= item.tick;
			item_s1.vbus_present  <= item.vbus_present;
			item_s1.polarity_done <= item.polarity_done;
			item_s1.scan_ready    <= item.scan_ready;
			item_s1.cc1_level     <= item.cc1_level;
			item_s1.cc2_level     <= item.cc2_level;
		end
	end

	// controller state: commits once per update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.fsm_state        <= ST_DETACHED;
			ctx_q.debounce_count   <= '0;
			ctx_q.debounce_running <= 1'b0;
			ctx_q.poll_count       <= '0;
			ctx_q.poll_running     <= 1'b0;
			ctx_q.last_cc1         <= '0;
			ctx_q.last_cc2         <= '0;
			ctx_q.port_attached    <= 1'b0;
		end else if (advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_nxt;
		end
	end

	assign result.valid            = result_valid_q;
	assign result.conn_state       = result_q.conn_state;
	assign result.attached_flag    = result_q.attached_flag;
	assign result.scan_request     = result_q.scan_request;
	assign result.polarity_request = result_q.polarity_request;
	assign result.polarity_choice  = result_q.polarity_choice;
	assign result.dpm_event        = result_q.dpm_event;

	// attached flag only ever set while in SINK_ATTACHED
	a_attached_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.port_attached |-> ctx_q.fsm_state == ST_ATTACHED)
		else $error("attached flag outside SINK_ATTACHED");

	// debounce timer only runs in DETACHED, poll timer only in DETECTING
	a_debounce_scope: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.debounce_running |-> ctx_q.fsm_state == ST_DETACHED)
		else $error("debounce timer running outside DETACHED");

	a_poll_scope: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.poll_running |-> ctx_q.fsm_state == ST_DETECTING)
		else $error("poll timer running outside DETECTING");

	// polarity choice is only meaningful with a request pulse
	a_choice_with_req: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.polarity_request) |->
			result_q.polarity_choice == POL_NONE)
		else $error("polarity choice without request");

	// attach event comes with attached state and flag
	a_attach_event: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.dpm_event == EVT_ATTACHED) |->
			(result_q.conn_state == ST_ATTACHED && result_q.attached_flag))
		else $error("attach event without attached state");

endmodule

// ===== tb/type_c_sink_attach_fsm_test.sv =====
module type_c_sink_attach_fsm_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcsa_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 6;
	localparam int QUIET_LIMIT    = 4000;	// cycles with no transfer of any kind
	localparam int MAX_REPORTS    = 10;
	localparam int SETTLE_CYCLES  = 4;	// two-stage pipeline plus margin

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	tcsa_item_if   item_ch ();
	tcsa_result_if result_ch ();

	type_c_sink_attach_fsm dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	// Updates waiting to be driven, and connection results still owed by the DUT.
	item_t   pending_updates [$];
	result_t expected_results [$];

	// Updates handed to the driver whose result has not been checked yet.
	int unsigned in_flight;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Shadow copy of the timing registers.
	logic [TICK_W-1:0] cfg_debounce;
	logic [TICK_W-1:0] cfg_poll;

	// Shadow copy of the connection controller.
	conn_state_t       fsm;
	logic [TICK_W-1:0] deb_cnt;
	logic              deb_on;
	logic [TICK_W-1:0] poll_cnt;
	logic              poll_on;
	logic [1:0]        scan_cc1;
	logic [1:0]        scan_cc2;
	logic              attached;

	// Update currently presented on the item channel.
	item_t drv_item;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Detach entry: clears the attach, kills debounce, reports the detach and
	// asks the port controller to drop polarity.
	function automatic void drop_to_detached(inout result_t r);
		fsm = ST_DETACHED;
		attached = 1'b0;
		deb_on = 1'b0;
		deb_cnt = '0;
		r.dpm_event = EVT_DETACHED;
		r.polarity_request = 1'b1;
		r.polarity_choice = POL_NONE;
	endfunction

	// One system update of the controller; returns the result it must emit.
	function automatic result_t sink_update(input item_t u);
		result_t r;
		logic    go;
		r = '0;
		// timers advance before any decision of this update
		if (u.tick) begin
			if (deb_on && deb_cnt != TICK_MAX)
				deb_cnt++;
			if (poll_on && poll_cnt != TICK_MAX)
				poll_cnt++;
		end
		case (fsm)
			ST_DETECTING: begin
				go = 1'b1;
				// a running poll timer blocks scan results until it expires
				if (poll_on) begin
					if (poll_cnt < cfg_poll) begin
						go = 1'b0;
					end else begin
						poll_on = 1'b0;
						poll_cnt = '0;
						r.scan_request = 1'b1;
					end
				end
				if (go && u.scan_ready) begin
					if (!u.vbus_present) begin
						poll_on = 1'b0;
						poll_cnt = '0;
						drop_to_detached(r);
					end else if (u.cc1_level != u.cc2_level && u.cc1_level == scan_cc1 &&
							u.cc2_level == scan_cc2) begin
						// two equal, unbalanced scans in a row: attach toward higher CC
						r.polarity_request = 1'b1;
						r.polarity_choice = (u.cc1_level > u.cc2_level) ? POL_CC1 : POL_CC2;
						poll_on = 1'b0;
						poll_cnt = '0;
						fsm = ST_ATTACHED;
					end else begin
						scan_cc1 = u.cc1_level;
						scan_cc2 = u.cc2_level;
						poll_on = 1'b1;
						poll_cnt = '0;
					end
				end
			end
			ST_ATTACHED: begin
				go = 1'b1;
				// attach is reported only once polarity has settled
				if (!attached) begin
					if (!u.polarity_done) begin
						go = 1'b0;
					end else begin
						attached = 1'b1;
						r.dpm_event = EVT_ATTACHED;
					end
				end
				// attach and VBUS loss in one update ends with the detach event
				if (go && !u.vbus_present)
					drop_to_detached(r);
			end
			default: begin
				// unused code falls back to detached
				fsm = ST_DETACHED;
				if (u.polarity_done) begin
					if (!u.vbus_present) begin
						deb_on = 1'b0;
						deb_cnt = '0;
					end else if (!deb_on) begin
						deb_on = 1'b1;
						deb_cnt = '0;
					end else if (deb_cnt >= cfg_debounce) begin
						deb_on = 1'b0;
						deb_cnt = '0;
						fsm = ST_DETECTING;
						scan_cc1 = '0;
						scan_cc2 = '0;
						poll_on = 1'b0;
						poll_cnt = '0;
						r.scan_request = 1'b1;
					end
				end
			end
		endcase
		r.conn_state = fsm;
		r.attached_flag = attached;
		return r;
	endfunction

	// Driver: predicts on every accepted transfer, then reloads from the queue.
	always @(posedge clk) begin : drive_updates
		item_t nxt;
		logic  load;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				expected_results.push_back(sink_update(drv_item));
			load = 1'b0;
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_updates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_updates.pop_front();
					load = 1'b1;
				end
				item_ch.valid <= load;
				if (load) begin
					drv_item = nxt;
					in_flight++;
					item_ch.tick          <= nxt.tick;
					item_ch.vbus_present  <= nxt.vbus_present;
					item_ch.polarity_done <= nxt.polarity_done;
					item_ch.scan_ready    <= nxt.scan_ready;
					item_ch.cc1_level     <= nxt.cc1_level;
					item_ch.cc2_level     <= nxt.cc2_level;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				got.conn_state       = conn_state_t'(result_ch.conn_state);
				got.attached_flag    = result_ch.attached_flag;
				got.scan_request     = result_ch.scan_request;
				got.polarity_request = result_ch.polarity_request;
				got.polarity_choice  = polarity_t'(result_ch.polarity_choice);
				got.dpm_event        = dpm_event_t'(result_ch.dpm_event);
				if (expected_results.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: result transfer with no update outstanding", $realtime);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					in_flight--;
					if (got !== want) begin
						if (mismatches < MAX_REPORTS)
							$display({"%0t: result mismatch, expected state %0d att %0b scan %0b ",
								"preq %0b pol %0d evt %0d, got state %0d att %0b scan %0b ",
								"preq %0b pol %0d evt %0d"}, $realtime,
								want.conn_state, want.attached_flag, want.scan_request,
								want.polarity_request, want.polarity_choice, want.dpm_event,
								got.conn_state, got.attached_flag, got.scan_request,
								got.polarity_request, got.polarity_choice, got.dpm_event);
						mismatches++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: any transfer on either stream or the register port resets it.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
					(psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("type_c_sink_attach_fsm_test: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// APB read with compare; prdata is taken at the access-phase edge.
	task automatic check_reg(input logic idx, input logic [TICK_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(CFG_DATA_W-TICK_W){1'b0}}, val}) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: register %0d reads %0h, expected %0h", $realtime, idx, prdata, val);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// APB write, then read back.
	task automatic write_reg(input logic idx, input logic [TICK_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(CFG_DATA_W-TICK_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_VBUS_DEBOUNCE)
			cfg_debounce = val;
		else
			cfg_poll = val;
		check_reg(idx, val);
	endtask

	task automatic set_timing(input logic [TICK_W-1:0] deb, input logic [TICK_W-1:0] poll);
		write_reg(REG_VBUS_DEBOUNCE, deb);
		write_reg(REG_CC_POLL, poll);
	endtask

	// Sender stays quiet until every queued update has come back, then lets
	// the pipeline settle so the registers can be touched safely.
	task automatic drain;
		while (pending_updates.size() != 0 || in_flight != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic item_t upd(input logic t, input logic v, input logic p, input logic s,
			input logic [1:0] c1, input logic [1:0] c2);
		item_t u;
		u.tick = t;
		u.vbus_present = v;
		u.polarity_done = p;
		u.scan_ready = s;
		u.cc1_level = c1;
		u.cc2_level = c2;
		return u;
	endfunction

	// Random traffic as plug sessions: VBUS up long enough to clear debounce,
	// repeated scans of one CC pair so detection can lock, then a short
	// VBUS-low tail to detach. Some sessions are pure noise.
	task automatic queue_sessions(input int unsigned n_items, input int unsigned tick_pct);
		int unsigned     left;
		int unsigned     len;
		int unsigned     tail;
		longint unsigned span;
		logic [1:0]      c1;
		logic [1:0]      c2;
		bit              noisy;
		item_t           u;
		left = n_items;
		while (left != 0) begin
			noisy = ($urandom_range(99) < 15);
			if (noisy)
				span = $urandom_range(10, 40);
			else
				span = (longint'(cfg_debounce) + 4 * longint'(cfg_poll)) * 100 / tick_pct +
					$urandom_range(8, 40);
			len = (span > left) ? left : int'(span);
			tail = $urandom_range(1, 4);
			c1 = 2'($urandom_range(3));
			c2 = 2'($urandom_range(3));
			if ($urandom_range(99) < 85)
				while (c2 == c1)
					c2 = 2'($urandom_range(3));
			for (int i = 0; i < len; i++) begin
				if (noisy) begin
					u = item_t'(8'($urandom));
				end else begin
					u.tick = ($urandom_range(99) < tick_pct);
					u.vbus_present = (i + tail < len);
					u.polarity_done = ($urandom_range(99) < 80);
					u.scan_ready = ($urandom_range(99) < 45);
					if ($urandom_range(99) < 88) begin
						u.cc1_level = c1;
						u.cc2_level = c2;
					end else begin
						u.cc1_level = 2'($urandom_range(3));
						u.cc2_level = 2'($urandom_range(3));
					end
				end
				pending_updates.push_back(u);
			end
			left -= len;
		end
	endtask

	// One operating point: timing, back-pressure mix, and traffic split by a
	// full drain in the middle.
	task automatic run_phase(input logic [TICK_W-1:0] deb, input logic [TICK_W-1:0] poll,
			input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned n_items, input int unsigned tick_pct);
		set_timing(deb, poll);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queue_sessions(n_items / 2, tick_pct);
		drain();
		queue_sessions(n_items - n_items / 2, tick_pct);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.tick = 1'b0;
		item_ch.vbus_present = 1'b0;
		item_ch.polarity_done = 1'b0;
		item_ch.scan_ready = 1'b0;
		item_ch.cc1_level = '0;
		item_ch.cc2_level = '0;
		result_ch.ready = 1'b0;
		in_flight = 0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// state after reset: a completed detach with nothing emitted
		cfg_debounce = VBUS_DEBOUNCE_RESET;
		cfg_poll = CC_POLL_RESET;
		fsm = ST_DETACHED;
		deb_cnt = '0;
		deb_on = 1'b0;
		poll_cnt = '0;
		poll_on = 1'b0;
		scan_cc1 = '0;
		scan_cc2 = '0;
		attached = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		check_reg(REG_VBUS_DEBOUNCE, VBUS_DEBOUNCE_RESET);
		check_reg(REG_CC_POLL, CC_POLL_RESET);

		// Directed walk with one-tick timers:
		// t, vbus, pol_done, scan_ready, cc1, cc2
		set_timing(1, 1);
		pending_updates.push_back(upd(0, 1, 0, 0, 0, 0));	// polarity pending: hold
		pending_updates.push_back(upd(0, 0, 1, 0, 0, 0));	// no VBUS
		pending_updates.push_back(upd(0, 1, 1, 0, 0, 0));	// debounce starts
		pending_updates.push_back(upd(1, 1, 1, 0, 0, 0));	// debounce done, detecting
		pending_updates.push_back(upd(0, 1, 1, 1, 3, 3));	// balanced scan, poll starts
		pending_updates.push_back(upd(0, 1, 1, 1, 1, 2));	// poll not expired, ignored
		pending_updates.push_back(upd(1, 1, 1, 0, 0, 0));	// poll expiry, rescan request
		pending_updates.push_back(upd(0, 1, 1, 1, 1, 2));	// new pair recorded
		pending_updates.push_back(upd(1, 1, 1, 1, 1, 2));	// match: attach toward CC2
		pending_updates.push_back(upd(0, 0, 0, 0, 0, 0));	// polarity pending masks VBUS loss
		pending_updates.push_back(upd(0, 1, 1, 0, 0, 0));	// attached event
		pending_updates.push_back(upd(1, 0, 0, 1, 3, 3));	// VBUS loss, detach
		pending_updates.push_back(upd(0, 1, 1, 0, 0, 0));
		pending_updates.push_back(upd(1, 1, 1, 0, 0, 0));
		pending_updates.push_back(upd(0, 1, 1, 1, 3, 0));
		pending_updates.push_back(upd(1, 1, 1, 1, 3, 0));	// attach toward CC1
		pending_updates.push_back(upd(1, 0, 1, 0, 2, 1));	// attach and detach together
		pending_updates.push_back(upd(0, 1, 1, 0, 0, 0));
		pending_updates.push_back(upd(1, 1, 1, 0, 0, 0));
		pending_updates.push_back(upd(0, 0, 1, 1, 2, 1));	// VBUS gone during scan
		pending_updates.push_back(upd(1, 1, 0, 1, 0, 3));
		drain();

		// Random phases: back-pressure mixes and timing extremes.
		run_phase(1, 1, 0, 0, 240, 60);
		run_phase(2, 1, 70, 0, 240, 60);
		run_phase(3, 2, 0, 70, 240, 60);
		run_phase(1, 3, 27, 27, 240, 60);
		run_phase(VBUS_DEBOUNCE_RESET, CC_POLL_RESET, 0, 0, 600, 95);
		run_phase(TICK_MAX, 1, 27, 27, 60, 60);
		run_phase(1, TICK_MAX, 0, 0, 60, 60);

		// drain() already waited out the pipeline; anything still owed is lost
		mismatches += expected_results.size();
		if (mismatches == 0)
			$display("type_c_sink_attach_fsm_test: done, clean");
		else
			$display("type_c_sink_attach_fsm_test: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/tcsa_pkg.sv
rtl/core/tcsa_if.sv
rtl/core/tcsa_cfg_regs.sv
rtl/core/tcsa_step.sv
rtl/core/type_c_sink_attach_fsm.sv
tb/type_c_sink_attach_fsm_test.sv
